/* rtl/assert_macros.svh */
// Assertion macros for the tachometer speed estimator RTL.
// Every macro expects the clock aclk and the active-low reset aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset
`define TSE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Condition that must never hold outside reset
`define TSE_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

`endif

/* rtl/tse_pkg.sv */
// Package for the tachometer speed estimator: widths, codes, reset values,
// shared structs and the loop-count speed table. No dependencies.
package tse_pkg;

    // Defaults of the top-level parameters
    localparam int CHANNELS_DEF       = 2;
    localparam int MAX_RING_DEPTH_DEF = 16;

    // Field and datapath widths
    localparam int VALUE_W    = 16;
    localparam int SCALE_W    = 32;
    localparam int LOG2_W     = 3;
    localparam int FUNC_W     = 2;
    localparam int SUM_W      = 20;   // 16 entries of 16 bits
    localparam int ALU_W      = 20;
    localparam int DIV_CNT_W  = 5;    // one quotient bit per step, 32 steps
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 24;   // capture_value, sensor_level, padding
    localparam int S_TUSER_W  = 4;    // func, channel, timer_reloaded
    localparam int M_TDATA_W  = 48;   // rpm, rpm_from_capture, rpm_from_count

    localparam logic [VALUE_W-1:0] VALUE_MAX = 16'hFFFF;

    // Function codes of an input word
    localparam logic [FUNC_W-1:0] FUNC_CAPTURE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RPM_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RPM   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AVG_LOG2  = 2'd2;

    // Configuration reset values
    localparam logic [SCALE_W-1:0] RPM_SCALE_RST = 32'd6000000;
    localparam logic [VALUE_W-1:0] MIN_RPM_RST   = 16'd50;
    localparam logic [LOG2_W-1:0]  AVG_LOG2_RST  = 3'd2;

    // Legal span of the ring size exponent
    localparam logic [LOG2_W-1:0] RING_LOG2_MIN = 3'd1;
    localparam logic [LOG2_W-1:0] RING_LOG2_MAX = 3'd4;

    // Loop-count thresholds and the speeds they map to
    localparam logic [VALUE_W-1:0] CNT_TH0 = 16'd120;
    localparam logic [VALUE_W-1:0] CNT_TH1 = 16'd150;
    localparam logic [VALUE_W-1:0] CNT_TH2 = 16'd200;
    localparam logic [VALUE_W-1:0] CNT_TH3 = 16'd300;
    localparam logic [VALUE_W-1:0] CNT_TH4 = 16'd600;
    localparam logic [VALUE_W-1:0] CNT_SP0 = 16'd65535;
    localparam logic [VALUE_W-1:0] CNT_SP1 = 16'd400;
    localparam logic [VALUE_W-1:0] CNT_SP2 = 16'd300;
    localparam logic [VALUE_W-1:0] CNT_SP3 = 16'd200;
    localparam logic [VALUE_W-1:0] CNT_SP4 = 16'd100;
    localparam logic [VALUE_W-1:0] CNT_SP5 = 16'd0;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAP_WR,
        ST_SUM,
        ST_AVG,
        ST_CLR,
        ST_TICK,
        ST_DIV,
        ST_RES
    } state_t;

    // One input word, unpacked
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic               channel;
        logic [VALUE_W-1:0] capture_value;
        logic               timer_reloaded;
        logic               sensor_level;
    } item_t;

    // Configuration registers
    typedef struct packed {
        logic [SCALE_W-1:0] rpm_scale;
        logic [VALUE_W-1:0] min_rpm;
        logic [LOG2_W-1:0]  avg_log2;
    } cfg_t;

    // One result word
    typedef struct packed {
        logic [VALUE_W-1:0] rpm;
        logic [VALUE_W-1:0] rpm_from_capture;
        logic [VALUE_W-1:0] rpm_from_count;
    } result_t;

    // Request to the shared add/subtract unit
    typedef struct packed {
        logic             sub;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    // Stepped speed from a saved loop count
    function automatic logic [VALUE_W-1:0] count_to_rpm(input logic [VALUE_W-1:0] cnt);
        logic [VALUE_W-1:0] sp;
        if (cnt < CNT_TH0) begin
            sp = CNT_SP0;
        end else if (cnt < CNT_TH1) begin
            sp = CNT_SP1;
        end else if (cnt < CNT_TH2) begin
            sp = CNT_SP2;
        end else if (cnt < CNT_TH3) begin
            sp = CNT_SP3;
        end else if (cnt < CNT_TH4) begin
            sp = CNT_SP4;
        end else begin
            sp = CNT_SP5;
        end
        return sp;
    endfunction

endpackage

/* rtl/tachometer_speed_estimator_unit.sv */
// Tick word: one count update, 32 division steps of the shared add/subtract
// unit, then a result state that loads the output register once it is free;
// a new word is taken in the cycle after the result is loaded.
// Capture word: ring write, a sum reading the ring one entry per cycle, average.
// Clear word: a single clear state. Reset is synchronous and active low; no clearing pass.
module tachometer_speed_estimator_unit #(
    parameter int CHANNELS       = tse_pkg::CHANNELS_DEF,
    parameter int MAX_RING_DEPTH = tse_pkg::MAX_RING_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tse_pkg::S_TDATA_W-1:0]     s_tdata,   // capture_value, sensor_level
    input  logic [tse_pkg::S_TUSER_W-1:0]     s_tuser,   // func, channel, timer_reloaded
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tse_pkg::M_TDATA_W-1:0]     m_tdata,   // rpm, rpm_from_capture, rpm_from_count
    // configuration writes
    input  logic                              cfg_we,
    input  logic [tse_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tse_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import tse_pkg::*;

    cfg_t    cfg_reg;
    item_t   in_item;
    result_t res;
    logic    res_load;
    logic    out_free;
    logic    m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Unpack the input word
    assign in_item.func           = s_tuser[1:0];
    assign in_item.channel        = s_tuser[2];
    assign in_item.timer_reloaded = s_tuser[3];
    assign in_item.capture_value  = s_tdata[15:0];
    assign in_item.sensor_level   = s_tdata[16];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rpm_scale <= RPM_SCALE_RST;
            cfg_reg.min_rpm   <= MIN_RPM_RST;
            cfg_reg.avg_log2  <= AVG_LOG2_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_RPM_SCALE: cfg_reg.rpm_scale <= cfg_wdata;
                REG_MIN_RPM:   cfg_reg.min_rpm   <= cfg_wdata[VALUE_W-1:0];
                REG_AVG_LOG2:  cfg_reg.avg_log2  <= cfg_wdata[LOG2_W-1:0];
                default: ;
            endcase
        end
    end

    tse_core #(
        .CHANNELS       (CHANNELS),
        .MAX_RING_DEPTH (MAX_RING_DEPTH)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .cfg      (cfg_reg),
        .out_free (out_free),
        .res_load (res_load),
        .res      (res)
    );

    // Output register: free when empty or being taken this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_tdata_reg <= {res.rpm_from_count, res.rpm_from_capture, res.rpm};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* rtl/tse_addsub.sv */
// Shared add/subtract unit of the speed estimator: ring summing and the
// restoring division both run through it. Uses tse_pkg.
module tse_addsub (
    input  tse_pkg::alu_req_t          req,
    output logic [tse_pkg::ALU_W:0]    res   // top bit: carry, or borrow on sub
);
    import tse_pkg::*;

    // Zero-extended add or subtract, top bit flags overflow / borrow
    assign res = req.sub ? ({1'b0, req.a} - {1'b0, req.b})
                         : ({1'b0, req.a} + {1'b0, req.b});

endmodule

/* rtl/tse_ring.sv */
// Capture ring memory of all channels, one row per channel, with one valid
// flop per entry so that unwritten or cleared entries read as 0xFFFF. Uses tse_pkg.
module tse_ring #(
    parameter int CHANNELS       = tse_pkg::CHANNELS_DEF,
    parameter int MAX_RING_DEPTH = tse_pkg::MAX_RING_DEPTH_DEF,
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int IDX_W = $clog2(MAX_RING_DEPTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [CH_W-1:0]               wr_ch,
    input  logic [IDX_W-1:0]              wr_idx,
    input  logic [tse_pkg::VALUE_W-1:0]   wr_data,
    input  logic                          rd_en,
    input  logic [CH_W-1:0]               rd_ch,
    input  logic [IDX_W-1:0]              rd_idx,
    output logic [tse_pkg::VALUE_W-1:0]   rd_data,
    input  logic                          clr_en,
    input  logic [CH_W-1:0]               clr_ch
);
    import tse_pkg::*;

    localparam int AW    = CH_W + IDX_W;
    localparam int DEPTH = 1 << AW;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   vld_reg, vld_next;
    logic [VALUE_W-1:0] rd_data_reg;
    logic               rd_vld_reg;
    logic [AW-1:0]      wr_addr, rd_addr;

    assign wr_addr = {wr_ch, wr_idx};
    assign rd_addr = {rd_ch, rd_idx};

    // Memory write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits: clear a whole row, set on write
    always_comb begin
        vld_next = vld_reg;
        if (clr_en) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (CH_W'(i >> IDX_W) == clr_ch) begin
                    vld_next[i] = 1'b0;
                end
            end
        end
        if (wr_en) begin
            vld_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // Entry never written since reset or clear reads as all ones
    assign rd_data = rd_vld_reg ? rd_data_reg : VALUE_MAX;

endmodule

/* rtl/tse_core.sv */
// Sequencer and per-channel state of the speed estimator: ring update and
// averaging, loop counter, and the bit-serial division on the shared unit.
// Uses tse_pkg, tse_ring, tse_addsub and assert_macros.svh.
`include "assert_macros.svh"

module tse_core #(
    parameter int CHANNELS       = tse_pkg::CHANNELS_DEF,
    parameter int MAX_RING_DEPTH = tse_pkg::MAX_RING_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  tse_pkg::item_t    in_item,
    input  tse_pkg::cfg_t     cfg,
    input  logic              out_free,
    output logic              res_load,
    output tse_pkg::result_t  res
);
    import tse_pkg::*;

    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IDX_W    = $clog2(MAX_RING_DEPTH);
    localparam int SZ_W     = IDX_W + 1;
    localparam int MAX_LOG2 = $clog2(MAX_RING_DEPTH + 1) - 1;

    state_t state_reg, state_next;
    item_t  item_reg;

    // Per-channel state
    logic [IDX_W-1:0]   pos_reg    [CHANNELS];
    logic [IDX_W-1:0]   pos_next   [CHANNELS];
    logic               filled_reg [CHANNELS];
    logic               filled_next[CHANNELS];
    logic [VALUE_W-1:0] avg_reg    [CHANNELS];
    logic [VALUE_W-1:0] avg_next   [CHANNELS];
    logic [VALUE_W-1:0] lc_reg     [CHANNELS];
    logic [VALUE_W-1:0] lc_next    [CHANNELS];
    logic [VALUE_W-1:0] saved_reg  [CHANNELS];
    logic [VALUE_W-1:0] saved_next [CHANNELS];
    logic               prev_reg   [CHANNELS];
    logic               prev_next  [CHANNELS];

    // Working registers
    logic [SZ_W-1:0]      idx_reg, idx_next;
    logic [SUM_W-1:0]     acc_reg, acc_next;
    logic [VALUE_W-1:0]   rem_reg, rem_next;
    logic [SCALE_W-1:0]   dq_reg, dq_next;
    logic [VALUE_W-1:0]   divisor_reg, divisor_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [VALUE_W-1:0]   cnt_speed_reg, cnt_speed_next;

    logic [CH_W-1:0]    ch_cur;
    logic               in_ch_ok;
    logic [LOG2_W-1:0]  n_clamp, ring_n;
    logic [SZ_W-1:0]    ring_size;
    logic [IDX_W-1:0]   pos_cur, pos_eff;
    logic [SZ_W-1:0]    pos_inc;
    logic               pos_wrap;
    logic [VALUE_W-1:0] lc_inc, lc_new, saved_new;
    logic               tick_rise;
    logic [VALUE_W:0]   rem_shift;
    logic               div_borrow;
    logic [VALUE_W-1:0] cap_speed;

    // Ring and shared unit connections
    logic               ring_wr_en, ring_rd_en, ring_clr_en;
    logic [IDX_W-1:0]   ring_wr_idx, ring_rd_idx;
    logic [VALUE_W-1:0] ring_wr_data, ring_rd_data;
    alu_req_t           alu_req;
    logic [ALU_W:0]     alu_res;

    tse_ring #(
        .CHANNELS       (CHANNELS),
        .MAX_RING_DEPTH (MAX_RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (ring_wr_en),
        .wr_ch   (ch_cur),
        .wr_idx  (ring_wr_idx),
        .wr_data (ring_wr_data),
        .rd_en   (ring_rd_en),
        .rd_ch   (ch_cur),
        .rd_idx  (ring_rd_idx),
        .rd_data (ring_rd_data),
        .clr_en  (ring_clr_en),
        .clr_ch  (ch_cur)
    );

    tse_addsub u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    // Channel of the word in hand and validity of an incoming one
    assign ch_cur   = CH_W'(item_reg.channel);
    assign in_ch_ok = (int'(in_item.channel) < CHANNELS);

    // Ring size exponent: clamp to 1..4, then to what the ring holds
    assign n_clamp = (cfg.avg_log2 < RING_LOG2_MIN) ? RING_LOG2_MIN :
                     (cfg.avg_log2 > RING_LOG2_MAX) ? RING_LOG2_MAX : cfg.avg_log2;
    assign ring_n    = (n_clamp > LOG2_W'(MAX_LOG2)) ? LOG2_W'(MAX_LOG2) : n_clamp;
    assign ring_size = SZ_W'(1) << ring_n;

    // Write position, restarted when it lies past a shrunk ring
    assign pos_cur  = pos_reg[ch_cur];
    assign pos_eff  = (SZ_W'(pos_cur) >= ring_size) ? '0 : pos_cur;
    assign pos_inc  = SZ_W'(pos_eff) + SZ_W'(1);
    assign pos_wrap = (pos_inc == ring_size);

    // Loop counter step for a tick
    assign lc_inc    = (lc_reg[ch_cur] != VALUE_MAX) ? lc_reg[ch_cur] + 16'd1
                                                     : lc_reg[ch_cur];
    assign tick_rise = item_reg.sensor_level && !prev_reg[ch_cur];
    assign saved_new = tick_rise ? lc_inc :
                       (saved_reg[ch_cur] < lc_inc) ? lc_inc : saved_reg[ch_cur];
    assign lc_new    = tick_rise ? '0 : lc_inc;

    // Restoring division step
    assign rem_shift  = {rem_reg, dq_reg[SCALE_W-1]};
    assign div_borrow = alu_res[ALU_W];

    // Capture speed from the quotient: saturate, then floor to zero
    assign cap_speed = (dq_reg > SCALE_W'(VALUE_MAX))     ? VALUE_MAX :
                       (dq_reg < SCALE_W'(cfg.min_rpm))   ? '0 : dq_reg[VALUE_W-1:0];

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid && in_ch_ok) begin
                    case (in_item.func)
                        FUNC_CAPTURE: state_next = ST_CAP_WR;
                        FUNC_TICK:    state_next = ST_TICK;
                        FUNC_CLEAR:   state_next = ST_CLR;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CAP_WR: state_next = ST_SUM;
            ST_SUM: begin
                if (idx_reg == ring_size) begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG:  state_next = ST_IDLE;
            ST_CLR:  state_next = ST_IDLE;
            ST_TICK: state_next = ST_DIV;
            ST_DIV: begin
                if (div_cnt_reg == '0) begin
                    state_next = ST_RES;
                end
            end
            ST_RES: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs: handshake, ring ports, shared unit operands
    always_comb begin
        in_ready     = 1'b0;
        res_load     = 1'b0;
        ring_wr_en   = 1'b0;
        ring_wr_idx  = pos_eff;
        ring_wr_data = item_reg.timer_reloaded ? VALUE_MAX : item_reg.capture_value;
        ring_rd_en   = 1'b0;
        ring_rd_idx  = idx_reg[IDX_W-1:0];
        ring_clr_en  = 1'b0;
        alu_req      = '0;
        case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_CAP_WR: ring_wr_en = 1'b1;
            ST_SUM: begin
                ring_rd_en = (idx_reg < ring_size);
                alu_req.a  = acc_reg;
                alu_req.b  = ALU_W'(ring_rd_data);
            end
            ST_CLR: ring_clr_en = 1'b1;
            ST_DIV: begin
                alu_req.sub = 1'b1;
                alu_req.a   = ALU_W'(rem_shift);
                alu_req.b   = ALU_W'(divisor_reg);
            end
            ST_RES: res_load = out_free;
            default: ;
        endcase
    end

    // Result word
    always_comb begin
        res.rpm_from_capture = cap_speed;
        res.rpm_from_count   = cnt_speed_reg;
        res.rpm              = (cap_speed < cnt_speed_reg) ? cap_speed : cnt_speed_reg;
    end

    // Datapath and per-channel state updates
    always_comb begin
        pos_next       = pos_reg;
        filled_next    = filled_reg;
        avg_next       = avg_reg;
        lc_next        = lc_reg;
        saved_next     = saved_reg;
        prev_next      = prev_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        divisor_next   = divisor_reg;
        div_cnt_next   = div_cnt_reg;
        cnt_speed_next = cnt_speed_reg;
        case (state_reg)
            ST_CAP_WR: begin
                pos_next[ch_cur] = pos_wrap ? '0 : pos_inc[IDX_W-1:0];
                if (pos_wrap) begin
                    filled_next[ch_cur] = 1'b1;
                end
                idx_next = '0;
                acc_next = '0;
            end
            ST_SUM: begin
                // read data is registered and arrives in the cycle after its index is issued
                if (idx_reg != '0) begin
                    acc_next = alu_res[SUM_W-1:0];
                end
                if (idx_reg != ring_size) begin
                    idx_next = idx_reg + SZ_W'(1);
                end
            end
            ST_AVG: begin
                avg_next[ch_cur] = filled_reg[ch_cur] ? VALUE_W'(acc_reg >> ring_n)
                                                      : VALUE_MAX;
            end
            ST_CLR: begin
                pos_next[ch_cur]    = '0;
                filled_next[ch_cur] = 1'b0;
                avg_next[ch_cur]    = VALUE_MAX;
            end
            ST_TICK: begin
                lc_next[ch_cur]    = lc_new;
                saved_next[ch_cur] = saved_new;
                prev_next[ch_cur]  = item_reg.sensor_level;
                cnt_speed_next     = count_to_rpm(saved_new);
                // a zero average divides as one
                divisor_next       = (avg_reg[ch_cur] == '0) ? 16'd1 : avg_reg[ch_cur];
                dq_next            = cfg.rpm_scale;
                rem_next           = '0;
                div_cnt_next       = '1;
            end
            ST_DIV: begin
                rem_next     = div_borrow ? rem_shift[VALUE_W-1:0] : alu_res[VALUE_W-1:0];
                dq_next      = {dq_reg[SCALE_W-2:0], ~div_borrow};
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
            end
            default: ;
        endcase
    end

    // Control and per-channel state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            for (int c = 0; c < CHANNELS; c++) begin
                pos_reg[c]    <= '0;
                filled_reg[c] <= 1'b0;
                avg_reg[c]    <= VALUE_MAX;
                lc_reg[c]     <= VALUE_MAX;
                saved_reg[c]  <= VALUE_MAX;
                prev_reg[c]   <= 1'b0;
            end
            idx_reg     <= '0;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            filled_reg  <= filled_next;
            avg_reg     <= avg_next;
            lc_reg      <= lc_next;
            saved_reg   <= saved_next;
            prev_reg    <= prev_next;
            idx_reg     <= idx_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        dq_reg        <= dq_next;
        divisor_reg   <= divisor_next;
        cnt_speed_reg <= cnt_speed_next;
    end

    // Checks
    `TSE_ASSERT(a_clear_avg, (state_reg == ST_CLR) |=> (avg_reg[ch_cur] == VALUE_MAX), "average not reset by clear word")
    `TSE_ASSERT(a_sum_done, (state_reg == ST_AVG) |-> (idx_reg == ring_size), "ring sum ended early")
    `TSE_ASSERT(a_rise_clear, (state_reg == ST_TICK && tick_rise) |=> (lc_reg[ch_cur] == '0), "loop counter kept after rising edge")
    `TSE_ASSERT(a_res_min, res_load |-> (res.rpm <= res.rpm_from_capture && res.rpm <= res.rpm_from_count), "speed is not the minimum")
    `TSE_ASSERT_NEVER(a_ring_access, ring_wr_en && (ring_clr_en || ring_rd_en), "ring write overlaps clear or read")

endmodule

/* tb/sv/tachometer_speed_estimator_unit_tb.sv */
// Self-checking testbench for tachometer_speed_estimator_unit: a directed table
// and phased random words, checked against the table's speeds where a row gives
// them, else an in-bench speed predictor. Depends on tse_pkg and the unit RTL only.
`timescale 1ns / 1ps

module tachometer_speed_estimator_unit_tb;
    import tse_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 80;
    localparam int DRAIN_CYCLES = 40;   // longest word is the tick
    localparam int DIR_ROWS     = 22;

    // Loop-count bands, lowest count first
    localparam logic [VALUE_W-1:0] BAND_EDGE [5] = '{CNT_TH0, CNT_TH1, CNT_TH2, CNT_TH3,
                                                     CNT_TH4};
    localparam logic [VALUE_W-1:0] BAND_RPM  [6] = '{CNT_SP0, CNT_SP1, CNT_SP2, CNT_SP3,
                                                     CNT_SP4, CNT_SP5};

    typedef enum int {RX_OPEN, RX_RANDOM, RX_THROTTLE} rx_mode_t;

    // One directed word; the speeds are only used where 'typed' is set
    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic               ch;
        logic [VALUE_W-1:0] period;
        logic               reloaded;
        logic               level;
        bit                 typed;
        logic [VALUE_W-1:0] rpm;
        logic [VALUE_W-1:0] cap;
        logic [VALUE_W-1:0] cnt;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // capture_value, sensor_level
    logic [S_TUSER_W-1:0]  s_tuser   = '0;   // func, channel, timer_reloaded
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // rpm, rpm_from_capture, rpm_from_count
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predictor copy of the registers and per-channel state
    logic [SCALE_W-1:0] scale_q    = RPM_SCALE_RST;
    logic [VALUE_W-1:0] min_rpm_q  = MIN_RPM_RST;
    logic [LOG2_W-1:0]  avg_log2_q = AVG_LOG2_RST;
    logic [VALUE_W-1:0] ring_mem [2][MAX_RING_DEPTH_DEF] = '{default: '{default: VALUE_MAX}};
    int unsigned        ring_wr_pos [2] = '{0, 0};
    logic               ring_full   [2] = '{1'b0, 1'b0};
    logic [VALUE_W-1:0] avg_period  [2] = '{VALUE_MAX, VALUE_MAX};
    logic [VALUE_W-1:0] tick_count  [2] = '{VALUE_MAX, VALUE_MAX};
    logic [VALUE_W-1:0] held_count  [2] = '{VALUE_MAX, VALUE_MAX};
    logic               last_level  [2] = '{1'b0, 1'b0};

    result_t     speeds_due[$];
    int          fail_count = 0;
    int          burst_left = 0;
    logic        lvl_now  [2] = '{1'b0, 1'b0};
    int unsigned lvl_left [2] = '{1, 1};

    dir_row_t dir_rows [DIR_ROWS] = '{
        // after reset: average 0xFFFF gives 91, no edge yet so count speed 0
        '{FUNC_TICK,    1'b0, 16'h0000, 1'b0, 1'b0, 1'b1, 16'd0,     16'd91,    16'd0},
        // first rising edge saves the saturated counter
        '{FUNC_TICK,    1'b0, 16'h0000, 1'b0, 1'b1, 1'b1, 16'd0,     16'd91,    16'd0},
        '{FUNC_TICK,    1'b0, 16'h0000, 1'b0, 1'b0, 1'b1, 16'd0,     16'd91,    16'd0},
        // short period: top band of the table
        '{FUNC_TICK,    1'b0, 16'h0000, 1'b0, 1'b1, 1'b1, 16'd91,    16'd91,    16'd65535},
        // unused function code
        '{FUNC_UNUSED,  1'b0, 16'hFFFF, 1'b1, 1'b0, 1'b0, 16'd0,     16'd0,     16'd0},
        // zero periods fill the ring: zero average divides as one, saturates
        '{FUNC_CAPTURE, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0,     16'd0},
        '{FUNC_CAPTURE, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0,     16'd0},
        '{FUNC_CAPTURE, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0,     16'd0},
        '{FUNC_CAPTURE, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0,     16'd0},
        '{FUNC_TICK,    1'b0, 16'h0000, 1'b0, 1'b1, 1'b1, 16'd65535, 16'd65535, 16'd65535},
        // largest period, then a reloaded timer stored as 0xFFFF
        '{FUNC_CAPTURE, 1'b0, 16'hFFFF, 1'b0, 1'b1, 1'b0, 16'd0,     16'd0,     16'd0},
        '{FUNC_CAPTURE, 1'b0, 16'h1234, 1'b1, 1'b0, 1'b0, 16'd0,     16'd0,     16'd0},
        '{FUNC_TICK,    1'b0, 16'h0000, 1'b0, 1'b1, 1'b0, 16'd0,     16'd0,     16'd0},
        // other channel untouched so far
        '{FUNC_TICK,    1'b1, 16'h0000, 1'b0, 1'b1, 1'b1, 16'd0,     16'd91,    16'd0},
        // clear brings the average back to 0xFFFF
        '{FUNC_CLEAR,   1'b0, 16'hABCD, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0,     16'd0},
        '{FUNC_TICK,    1'b0, 16'h0000, 1'b0, 1'b0, 1'b1, 16'd91,    16'd91,    16'd65535},
        '{FUNC_CAPTURE, 1'b1, 16'h0001, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0,     16'd0},
        '{FUNC_CAPTURE, 1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0,     16'd0},
        '{FUNC_CAPTURE, 1'b1, 16'h8000, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0,     16'd0},
        '{FUNC_CAPTURE, 1'b1, 16'h7FFF, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0,     16'd0},
        '{FUNC_TICK,    1'b1, 16'h0000, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0,     16'd0},
        '{FUNC_UNUSED,  1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b0, 16'd0,     16'd0,     16'd0}
    };

    tachometer_speed_estimator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    // Ring size exponent after saturation to the legal span and to the ring depth
    function automatic int unsigned ring_bits();
        int unsigned n;
        n = avg_log2_q;
        if (n < RING_LOG2_MIN) n = RING_LOG2_MIN;
        if (n > RING_LOG2_MAX) n = RING_LOG2_MAX;
        while (n > 1 && (1 << n) > MAX_RING_DEPTH_DEF) n--;
        return n;
    endfunction

    task automatic store_capture(input int ch, input logic [VALUE_W-1:0] period,
                                 input logic reloaded);
        int unsigned      n;
        int unsigned      size;
        int unsigned      pos;
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] mean;
        n    = ring_bits();
        size = 1 << n;
        pos  = ring_wr_pos[ch];
        // a shrunk ring restarts at entry 0
        if (pos >= size) pos = 0;
        ring_mem[ch][pos] = reloaded ? VALUE_MAX : period;
        pos++;
        if (pos == size) begin
            pos = 0;
            ring_full[ch] = 1'b1;
        end
        ring_wr_pos[ch] = pos;
        sum = '0;
        for (int i = 0; i < size; i++) sum += ring_mem[ch][i];
        mean = sum >> n;
        avg_period[ch] = ring_full[ch] ? mean[VALUE_W-1:0] : VALUE_MAX;
    endtask

    task automatic clear_ring(input int ch);
        for (int i = 0; i < MAX_RING_DEPTH_DEF; i++) ring_mem[ch][i] = VALUE_MAX;
        ring_wr_pos[ch] = 0;
        ring_full[ch]   = 1'b0;
        avg_period[ch]  = VALUE_MAX;
    endtask

    function automatic logic [VALUE_W-1:0] band_speed(input logic [VALUE_W-1:0] cnt);
        for (int i = 0; i < 5; i++)
            if (cnt < BAND_EDGE[i]) return BAND_RPM[i];
        return BAND_RPM[5];
    endfunction

    task automatic tick_speeds(input int ch, input logic level, output result_t r);
        logic [SCALE_W-1:0] divisor;
        logic [SCALE_W-1:0] quot;
        logic [VALUE_W-1:0] cap;
        logic [VALUE_W-1:0] cnt;
        // capture speed from the stored average (zero divides as one)
        divisor = (avg_period[ch] == '0) ? 32'd1 : {16'd0, avg_period[ch]};
        quot    = scale_q / divisor;
        if (quot > {16'd0, VALUE_MAX}) cap = VALUE_MAX;
        else if (quot < {16'd0, min_rpm_q}) cap = '0;
        else cap = quot[VALUE_W-1:0];
        // saturating loop counter; the held count takes it on a rising edge, else keeps the larger
        if (tick_count[ch] != VALUE_MAX) tick_count[ch]++;
        if (level && !last_level[ch]) begin
            held_count[ch] = tick_count[ch];
            tick_count[ch] = '0;
        end else if (held_count[ch] < tick_count[ch]) begin
            held_count[ch] = tick_count[ch];
        end
        last_level[ch] = level;
        cnt = band_speed(held_count[ch]);
        r.rpm              = (cap < cnt) ? cap : cnt;
        r.rpm_from_capture = cap;
        r.rpm_from_count   = cnt;
    endtask

    task automatic predict(input item_t w, output bit has_result, output result_t r);
        has_result = 1'b0;
        r = '0;
        case (w.func)
            FUNC_CAPTURE: store_capture(w.channel, w.capture_value, w.timer_reloaded);
            FUNC_CLEAR:   clear_ring(w.channel);
            FUNC_TICK: begin
                tick_speeds(w.channel, w.sensor_level, r);
                has_result = 1'b1;
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------- stimulus

    // Send one word; called at a clock edge, returns at the edge that takes it
    task automatic send_word(input item_t w, input bit typed, input result_t want);
        bit      has_result;
        result_t r;
        s_tdata  <= {{(S_TDATA_W - VALUE_W - 1){1'b0}}, w.sensor_level, w.capture_value};
        s_tuser  <= {w.timer_reloaded, w.channel, w.func};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict(w, has_result, r);
        if (has_result) speeds_due.push_back(typed ? want : r);
    endtask

    // Bursts of back-to-back words with random gaps between them
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
            burst_left = $urandom_range(0, 20);
        end
    endtask

    // Idle the input and let the unit drain before touching registers
    task automatic settle();
        s_tvalid <= 1'b0;
        while (speeds_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [SCALE_W-1:0] scale,
                                input logic [VALUE_W-1:0] min_rpm,
                                input logic [LOG2_W-1:0] lg);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RPM_SCALE;
        cfg_wdata <= scale;
        @(posedge aclk);
        cfg_index <= REG_MIN_RPM;
        cfg_wdata <= {16'd0, min_rpm};
        @(posedge aclk);
        cfg_index <= REG_AVG_LOG2;
        cfg_wdata <= {{(CFG_DATA_W - LOG2_W){1'b0}}, lg};
        @(posedge aclk);
        cfg_we     <= 1'b0;
        scale_q    = scale;
        min_rpm_q  = min_rpm;
        avg_log2_q = lg;
    endtask

    // Period values spread over the tiny, typical and saturated ranges
    function automatic logic [VALUE_W-1:0] pick_period();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom_range(0, 40));
            1:       return 16'($urandom_range(41, 2000));
            2:       return 16'($urandom_range(2001, 65534));
            3:       return VALUE_MAX;
            default: return 16'($urandom());
        endcase
    endfunction

    // Sensor waveform per channel; channel 0 often gets long periods so the
    // saved count climbs through every band of the table
    function automatic logic next_level(input int ch);
        logic level;
        if ($urandom_range(0, 19) == 0) return 1'($urandom_range(0, 1));
        level = lvl_now[ch];
        if (lvl_left[ch] <= 1) begin
            lvl_now[ch] = ~lvl_now[ch];
            if (ch == 0 && $urandom_range(0, 1) == 1) lvl_left[ch] = $urandom_range(60, 200);
            else if (ch == 1 && $urandom_range(0, 5) == 0) lvl_left[ch] = $urandom_range(60, 100);
            else lvl_left[ch] = $urandom_range(1, 8);
        end else begin
            lvl_left[ch]--;
        end
        return level;
    endfunction

    initial begin : drive_words
        item_t   w;
        result_t want;
        int      pick;
        logic    focus;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table at reset register values
        foreach (dir_rows[i]) begin
            w.func           = dir_rows[i].func;
            w.channel        = dir_rows[i].ch;
            w.capture_value  = dir_rows[i].period;
            w.timer_reloaded = dir_rows[i].reloaded;
            w.sensor_level   = dir_rows[i].level;
            want = '{dir_rows[i].rpm, dir_rows[i].cap, dir_rows[i].cnt};
            send_word(w, dir_rows[i].typed, want);
            pace();
        end

        // random phases, registers rewritten between them
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0:       program_regs(32'hFFFF_FFFF, 16'd0, 3'd4);
                1:       program_regs(32'd1, 16'd0, 3'd0);
                2:       program_regs(RPM_SCALE_RST, 16'hFFFF, 3'd7);
                default: program_regs($urandom_range(200000, 30000000),
                                      16'($urandom_range(0, 300)),
                                      3'($urandom_range(0, 7)));
            endcase
            focus = (ph % 3 == 2);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 3) w.func = FUNC_UNUSED;
                else if (pick < 5) w.func = FUNC_CLEAR;
                else if (pick < 40) w.func = FUNC_CAPTURE;
                else w.func = FUNC_TICK;
                w.channel        = ($urandom_range(0, 9) < 7) ? focus : ~focus;
                w.capture_value  = pick_period();
                w.timer_reloaded = ($urandom_range(0, 9) == 0);
                if (w.func == FUNC_TICK) w.sensor_level = next_level(w.channel);
                else w.sensor_level = 1'($urandom_range(0, 1));
                send_word(w, 1'b0, '0);
                pace();
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // ---------------------------------------------------------------- results

    // Receiver ready: open stretches, random stalls and a slow throttle
    initial begin : result_ready
        rx_mode_t    mode;
        int unsigned cyc;
        cyc = 0;
        forever begin
            mode = rx_mode_t'($urandom_range(0, 2));
            repeat ($urandom_range(20, 120)) begin
                @(posedge aclk);
                cyc++;
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
                    default:   m_tready <= (cyc[3:2] == 2'b11);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : check_speeds
        result_t want;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (speeds_due.size() == 0) begin
                $error("result word with no speed expected: %h", m_tdata);
                fail_count++;
            end else begin
                want = speeds_due.pop_front();
                // m_tdata carries rpm in the low bits, so the packed order is reversed
                got.rpm              = m_tdata[15:0];
                got.rpm_from_capture = m_tdata[31:16];
                got.rpm_from_count   = m_tdata[47:32];
                if (got.rpm !== want.rpm) begin
                    $error("rpm: expected %0d, got %0d", want.rpm, got.rpm);
                    fail_count++;
                end
                if (got.rpm_from_capture !== want.rpm_from_capture) begin
                    $error("rpm_from_capture: expected %0d, got %0d",
                           want.rpm_from_capture, got.rpm_from_capture);
                    fail_count++;
                end
                if (got.rpm_from_count !== want.rpm_from_count) begin
                    $error("rpm_from_count: expected %0d, got %0d",
                           want.rpm_from_count, got.rpm_from_count);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog, several times the slowest legal run
    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

endmodule
